>>> rtl/eeb_pkg.sv
package eeb_pkg;

   // default operand width
   localparam int EEB_WIDTH = 32;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;        // capture operands, seed coefficient pairs
      logic div_start;   // clear partial remainder and product accumulators, load dividend
      logic div_step;    // one restoring division step
      logic update;      // rotate remainder and coefficient pairs
   } eeb_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic rem_zero;    // current remainder is zero: algorithm finished
   } eeb_status_type;

endpackage

>>> rtl/eeb_dpath.sv
module eeb_dpath
   import eeb_pkg::*;
#(
   parameter int WIDTH = EEB_WIDTH
) (
   input  logic                 clock,
   input  eeb_cmd_type          cmd,
   output eeb_status_type       status,
   input  logic [WIDTH-1:0]     first_value,
   input  logic [WIDTH-1:0]     second_value,
   output logic [WIDTH-1:0]     greatest_divisor,
   output logic signed [WIDTH:0] coef_a,
   output logic signed [WIDTH:0] coef_b
);

   // remainder pair, coefficient pairs
   logic [WIDTH-1:0] r_old_ff, r_old_in, r_new_ff, r_new_in;
   logic [WIDTH:0]   s_old_ff, s_old_in, s_new_ff, s_new_in;
   logic [WIDTH:0]   t_old_ff, t_old_in, t_new_ff, t_new_in;
   // divider: partial remainder and dividend shift register
   logic [WIDTH-1:0] rem_ff, rem_in, dvd_ff, dvd_in;
   // running products q*s_new and q*t_new, built MSB first
   logic [WIDTH:0]   s_acc_ff, s_acc_in, t_acc_ff, t_acc_in;

   logic [WIDTH:0]   part;
   logic [WIDTH+1:0] diff;
   logic             qbit;

   // trial subtract of the divisor from the shifted partial remainder
   assign part = {rem_ff, dvd_ff[WIDTH-1]};
   assign diff = {1'b0, part} - {2'b00, r_new_ff};
   assign qbit = ~diff[WIDTH+1];

   always_comb begin
      r_old_in = r_old_ff;
      r_new_in = r_new_ff;
      s_old_in = s_old_ff;
      s_new_in = s_new_ff;
      t_old_in = t_old_ff;
      t_new_in = t_new_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      s_acc_in = s_acc_ff;
      t_acc_in = t_acc_ff;
      if (cmd.load) begin
         r_old_in = first_value;
         r_new_in = second_value;
         s_old_in = (WIDTH+1)'(1);
         s_new_in = '0;
         t_old_in = '0;
         t_new_in = (WIDTH+1)'(1);
      end
      if (cmd.div_start) begin
         rem_in   = '0;
         dvd_in   = r_old_ff;
         s_acc_in = '0;
         t_acc_in = '0;
      end
      if (cmd.div_step) begin
         // keep the difference when it did not borrow
         rem_in   = qbit ? diff[WIDTH-1:0] : part[WIDTH-1:0];
         dvd_in   = {dvd_ff[WIDTH-2:0], 1'b0};
         s_acc_in = {s_acc_ff[WIDTH-1:0], 1'b0} + (qbit ? s_new_ff : '0);
         t_acc_in = {t_acc_ff[WIDTH-1:0], 1'b0} + (qbit ? t_new_ff : '0);
      end
      if (cmd.update) begin
         // (old, new) <- (new, old - q*new)
         r_old_in = r_new_ff;
         r_new_in = rem_ff;
         s_old_in = s_new_ff;
         s_new_in = s_old_ff - s_acc_ff;
         t_old_in = t_new_ff;
         t_new_in = t_old_ff - t_acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      r_old_ff <= r_old_in;
      r_new_ff <= r_new_in;
      s_old_ff <= s_old_in;
      s_new_ff <= s_new_in;
      t_old_ff <= t_old_in;
      t_new_ff <= t_new_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      s_acc_ff <= s_acc_in;
      t_acc_ff <= t_acc_in;
   end

   assign status.rem_zero  = (r_new_ff == '0);
   assign greatest_divisor = r_old_ff;
   assign coef_a           = s_old_ff;
   assign coef_b           = t_old_ff;

endmodule

>>> rtl/eeb_ctrl.sv
module eeb_ctrl
   import eeb_pkg::*;
#(
   parameter int WIDTH = EEB_WIDTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   output logic           done,
   output eeb_cmd_type    cmd,
   input  eeb_status_type status
);

   localparam int CNT_W = $clog2(WIDTH);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // sequence: load, then per round test, divide, rotate
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.rem_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_start = 1'b1;
               cnt_in        = CNT_W'(WIDTH - 1);
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_UPDATE;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign done = (state_ff == ST_DONE);

endmodule

>>> rtl/extended_euclid_bezout.sv
// Extended Euclid: gcd of two unsigned operands plus Bezout coefficients.
//
// Request: drive req_first_value / req_second_value and raise start; the
// word is taken at the clock edge where start is high and busy is low.
// busy stays high from the next cycle until the result has been shown.
// Response: rsp_valid is high for exactly one cycle with rsp_greatest_divisor
// and the two's complement coefficients rsp_coef_a / rsp_coef_b, so that
// a*coef_a + b*coef_b = gcd. The receiver cannot stall; the word is
// taken in that cycle.
// The work runs in R Euclid rounds (0 when the second operand is zero, at
// most about 1.44*WIDTH+2). Each round runs a restoring divider, one
// quotient bit per cycle, that also builds q*s and q*t by shift-and-add;
// one item is in work at a time and a new one can start the cycle after
// the strobe.
// Reset (synchronous, active high) returns the controller to idle and
// drops any item in work; no result is given for it.
module extended_euclid_bezout
   import eeb_pkg::*;
#(
   parameter int WIDTH = EEB_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [WIDTH-1:0]      req_first_value,
   input  logic [WIDTH-1:0]      req_second_value,
   output logic                  rsp_valid,
   output logic [WIDTH-1:0]      rsp_greatest_divisor,
   output logic signed [WIDTH:0] rsp_coef_a,
   output logic signed [WIDTH:0] rsp_coef_b
);

   eeb_cmd_type    cmd;
   eeb_status_type status;

   eeb_ctrl #(
      .WIDTH (WIDTH)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .done   (rsp_valid),
      .cmd    (cmd),
      .status (status)
   );

   eeb_dpath #(
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .first_value      (req_first_value),
      .second_value     (req_second_value),
      .greatest_divisor (rsp_greatest_divisor),
      .coef_a           (rsp_coef_a),
      .coef_b           (rsp_coef_b)
   );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench
   import eeb_pkg::*;
();

   localparam int W = EEB_WIDTH;
   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 10;
   // longest time from a word taken to its strobe: every Euclid round run out
   localparam int SETTLE_CYCLES = 2 + (3 * W / 2 + 2) * (W + 2);
   localparam int RANDOM_WORDS = 340;
   localparam int DRAIN_GROUPS = 6;

   // gcd and Bezout pair the block should return for one operand pair
   typedef struct {
      logic [W-1:0]        gcd;
      logic signed [W:0]   coef_x;
      logic signed [W:0]   coef_y;
   } bezout_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic [W-1:0]         req_first_value = '0;
   logic [W-1:0]         req_second_value = '0;
   logic                 busy;
   logic                 rsp_valid;
   logic [W-1:0]         rsp_greatest_divisor;
   logic signed [W:0]    rsp_coef_a;
   logic signed [W:0]    rsp_coef_b;

   bezout_word_type      bezout_pending[$];
   bezout_word_type      bezout_front;
   int                   words_sent = 0;
   int                   fail_count = 0;

   extended_euclid_bezout #(
      .WIDTH(W)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_first_value      (req_first_value),
      .req_second_value     (req_second_value),
      .rsp_valid            (rsp_valid),
      .rsp_greatest_divisor (rsp_greatest_divisor),
      .rsp_coef_a           (rsp_coef_a),
      .rsp_coef_b           (rsp_coef_b)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Run the remainder and coefficient pairs down to a zero remainder,
   // all in 64-bit wraparound arithmetic so negative coefficients fall out
   // as two's complement.
   function automatic bezout_word_type bezout_solve(input logic [W-1:0] a,
                                                    input logic [W-1:0] b);
      logic [63:0]     r_old, r_new, s_old, s_new, t_old, t_new, q, held;
      bezout_word_type result;
      r_old = 64'(a);
      r_new = 64'(b);
      s_old = 64'd1;
      s_new = 64'd0;
      t_old = 64'd0;
      t_new = 64'd1;
      while (r_new != 64'd0) begin
         q = r_old / r_new;
         held = r_new;
         r_new = r_old - q * r_new;
         r_old = held;
         held = s_new;
         s_new = s_old - q * s_new;
         s_old = held;
         held = t_new;
         t_new = t_old - q * t_new;
         t_old = held;
      end
      result.gcd = r_old[W-1:0];
      result.coef_x = s_old[W:0];
      result.coef_y = t_old[W:0];
      return result;
   endfunction

   // Offer one word and hold it until the block takes it; start stays high
   // so a following word can go out back to back.
   task automatic send_word(input logic [W-1:0] a, input logic [W-1:0] b);
      req_first_value <= a;
      req_second_value <= b;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      bezout_pending.push_back(bezout_solve(a, b));
      words_sent++;
   endtask

   // Drop start for a number of cycles.
   task automatic hold_idle(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Hold off until every expected result has come back.
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (bezout_pending.size() != 0) @(posedge clock);
   endtask

   // Pick an operand pair from a mix of shapes: plain random, shared factors,
   // tiny values, zeros, equal values, short words and near neighbors.
   task automatic pick_operands(output logic [W-1:0] a, output logic [W-1:0] b);
      int unsigned factor;
      int unsigned shape;
      shape = $urandom_range(0, 11);
      a = W'($urandom);
      b = W'($urandom);
      case (shape)
         4, 5: begin
            factor = $urandom_range(2, 65535);
            a = W'(factor * $urandom_range(0, 32'hFFFF_FFFF / factor));
            b = W'(factor * $urandom_range(0, 32'hFFFF_FFFF / factor));
         end
         6: begin
            a = W'($urandom_range(0, 255));
            b = W'($urandom_range(0, 255));
         end
         7: begin
            if ($urandom_range(0, 1) == 0) a = '0;
            else b = '0;
         end
         8: b = a;
         9: begin
            a = a >> $urandom_range(0, W - 1);
            b = b >> $urandom_range(0, W - 1);
         end
         10: b = a - W'($urandom_range(0, 15));
         default: ;
      endcase
   endtask

   // Corner operands: zeros, ones, full scale, powers of two, primes,
   // alternating bits and the worst-case consecutive Fibonacci pair.
   task automatic test_corner_operands();
      send_word('0, '0);
      send_word('1, '0);
      send_word('0, '1);
      send_word('0, W'(12345));
      send_word(W'(77), '0);
      send_word('1, '1);
      send_word(W'(1), W'(1));
      send_word('1, W'(1));
      send_word(W'(1), '1);
      send_word('1, '1 - W'(1));
      send_word(W'(32'd2971215073), W'(32'd1836311903));
      send_word(W'(32'd1836311903), W'(32'd2971215073));
      send_word(W'(32'h8000_0000), W'(32'h4000_0000));
      send_word('1, W'(32'h8000_0000));
      send_word(W'(32'd4294967291), W'(32'd4294967279));
      send_word(W'(32'hAAAA_AAAA), W'(32'h5555_5555));
      send_word(W'(32'h5555_5555), W'(32'hAAAA_AAAA));
      send_word(W'(12), W'(18));
      send_word(W'(240), W'(46));
      send_word(W'(32'hDEAD_BEEF), W'(32'hDEAD_BEEF));
      wait_drained();
   endtask

   // Random words in bursts of random length; gaps are mostly short with
   // the odd long one so the next start lands at any point of the work.
   task automatic test_random_bursts();
      logic [W-1:0] a, b;
      int           burst_len;
      int           gap;
      int           sent_here;
      sent_here = 0;
      while (sent_here < RANDOM_WORDS) begin
         burst_len = $urandom_range(1, 8);
         repeat (burst_len) begin
            pick_operands(a, b);
            send_word(a, b);
            sent_here++;
         end
         case ($urandom_range(0, 7))
            0: gap = $urandom_range(0, SETTLE_CYCLES);
            1, 2: gap = 0;
            default: gap = $urandom_range(1, 6);
         endcase
         hold_idle(gap);
      end
   endtask

   // Short groups, each followed by a full drain before the next one.
   task automatic test_drain_pauses();
      logic [W-1:0] a, b;
      repeat (DRAIN_GROUPS) begin
         repeat ($urandom_range(1, 8)) begin
            pick_operands(a, b);
            send_word(a, b);
         end
         wait_drained();
         hold_idle($urandom_range(0, 3));
      end
   endtask

   // Compare each strobed word against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (bezout_pending.size() == 0) begin
            $display("%0t: unexpected result gcd=%0d coef_a=%0d coef_b=%0d", $time,
                     rsp_greatest_divisor, rsp_coef_a, rsp_coef_b);
            fail_count++;
         end else begin
            bezout_front = bezout_pending.pop_front();
            if (rsp_greatest_divisor !== bezout_front.gcd) begin
               $display("%0t: gcd mismatch expected %0d actual %0d", $time,
                        bezout_front.gcd, rsp_greatest_divisor);
               fail_count++;
            end
            if (rsp_coef_a !== bezout_front.coef_x) begin
               $display("%0t: coef_a mismatch expected %0d actual %0d", $time,
                        bezout_front.coef_x, rsp_coef_a);
               fail_count++;
            end
            if (rsp_coef_b !== bezout_front.coef_y) begin
               $display("%0t: coef_b mismatch expected %0d actual %0d", $time,
                        bezout_front.coef_y, rsp_coef_b);
               fail_count++;
            end
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_operands();
      test_random_bursts();
      test_drain_pauses();
      // drain, then give any stray strobe time to show up
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("extended_euclid_bezout test passed");
      end else begin
         $display("extended_euclid_bezout test failed");
      end
      $finish;
   end

   // Stop a hung run.
   initial begin
      #60_000_000;
      $display("extended_euclid_bezout test failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/eeb_pkg.sv
rtl/eeb_dpath.sv
rtl/eeb_ctrl.sv
rtl/extended_euclid_bezout.sv
verif/testbench.sv
